[design/ssev_pkg.sv]
// Shared types, constants and helper functions of the seashell surface evaluator.
package ssev_pkg;

  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 18;

  // Trig values are Q2.30 carried in 33 bits.
  localparam int TRIG_BITS = 30;
  localparam int TRIG_W    = 33;
  localparam int ATAN_COUNT = 30;

  typedef logic signed [TRIG_W-1:0] trig_t;

  localparam trig_t TRIG_ONE = trig_t'(64'd1 << TRIG_BITS);

  localparam logic [30:0] PI_Q29         = 31'd1686629713;
  localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
  localparam longint unsigned CORDIC_GAIN  = 64'd652032874;
  localparam longint unsigned TWO_K_THIRDS = (2 * CORDIC_GAIN) / 3;

  // Register indexes on the configuration port.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SHELL_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHELL_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_RADIUS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_COUNT   = 2'd3;

  // One CORDIC rotation: coordinates, residual angle and the half-turn flag.
  typedef struct packed {
    logic signed [TRIG_W-1:0] x;
    logic signed [TRIG_W-1:0] y;
    logic signed [TRIG_W-1:0] z;
    logic                     flip;
  } cordic_t;

  // atan(2^-i) in Q2.30.
  function automatic trig_t atan_q30(input int idx);
    logic [31:0] val;
    case (idx)
      0:  val = 32'd843314857;
      1:  val = 32'd497837829;
      2:  val = 32'd263043837;
      3:  val = 32'd133525159;
      4:  val = 32'd67021687;
      5:  val = 32'd33543516;
      6:  val = 32'd16775851;
      7:  val = 32'd8388437;
      8:  val = 32'd4194283;
      9:  val = 32'd2097149;
      10: val = 32'd1048576;
      11: val = 32'd524288;
      12: val = 32'd262144;
      13: val = 32'd131072;
      14: val = 32'd65536;
      15: val = 32'd32768;
      16: val = 32'd16384;
      17: val = 32'd8192;
      18: val = 32'd4096;
      19: val = 32'd2048;
      20: val = 32'd1024;
      21: val = 32'd512;
      22: val = 32'd256;
      23: val = 32'd128;
      24: val = 32'd64;
      25: val = 32'd32;
      26: val = 32'd16;
      27: val = 32'd8;
      28: val = 32'd4;
      29: val = 32'd2;
      default: val = 32'd0;
    endcase
    return trig_t'(val);
  endfunction

  // Start value of x: the CORDIC gain with a correction for a finite chain.
  function automatic trig_t cordic_x0(input int steps);
    longint unsigned corr;
    corr = (TWO_K_THIRDS + (64'd1 << (2 * steps - 1))) >> (2 * steps);
    return trig_t'(CORDIC_GAIN + corr);
  endfunction

  // Cycles from an accepted item to its result strobe.
  function automatic int latency(input int steps);
    return steps + 8;
  endfunction

endpackage

[design/ssev_cordic_cell.sv]
// One CORDIC rotation step, registered.
module ssev_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic              clk_i,
  input  ssev_pkg::cordic_t rot_i,
  output ssev_pkg::cordic_t rot_o
);
  import ssev_pkg::*;

  localparam trig_t ANGLE = atan_q30(IDX);

  cordic_t rot_d, rot_q;

  always_comb begin
    rot_d.flip = rot_i.flip;
    if (!rot_i.z[TRIG_W-1]) begin
      rot_d.x = rot_i.x - (rot_i.y >>> IDX);
      rot_d.y = rot_i.y + (rot_i.x >>> IDX);
      rot_d.z = rot_i.z - ANGLE;
    end else begin
      rot_d.x = rot_i.x + (rot_i.y >>> IDX);
      rot_d.y = rot_i.y - (rot_i.x >>> IDX);
      rot_d.z = rot_i.z + ANGLE;
    end
  end

  always_ff @(posedge clk_i) begin
    rot_q <= rot_d;
  end

  assign rot_o = rot_q;

endmodule

[design/ssev_cordic.sv]
// Cosine and sine of a turn fraction through a chain of CORDIC cells.
module ssev_cordic #(
  parameter int STEPS = ssev_pkg::CORDIC_STEPS_DEF
) (
  input  logic                clk_i,
  input  logic [31:0]         phase_i,
  output ssev_pkg::trig_t     cos_o,
  output ssev_pkg::trig_t     sin_o
);
  import ssev_pkg::*;

  localparam trig_t X0 = cordic_x0(STEPS);

  logic [31:0]        shifted;
  logic               flip;
  logic [31:0]        phase_r;
  logic signed [63:0] z_prod;
  cordic_t            chain [STEPS+1];
  trig_t              cos_q, sin_q;

  // Fold the left half plane onto the right one and remember the sign.
  assign shifted = phase_i + 32'h4000_0000;
  assign flip    = shifted[31];
  assign phase_r = flip ? (phase_i - 32'h8000_0000) : phase_i;
  assign z_prod  = $signed(phase_r) * $signed({1'b0, PI_Q29});

  always_ff @(posedge clk_i) begin
    chain[0].x    <= X0;
    chain[0].y    <= '0;
    chain[0].z    <= z_prod[62:30];
    chain[0].flip <= flip;
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    ssev_cordic_cell #(.IDX(i)) u_cell (
      .clk_i (clk_i),
      .rot_i (chain[i]),
      .rot_o (chain[i+1])
    );
  end

  always_ff @(posedge clk_i) begin
    cos_q <= chain[STEPS].flip ? -chain[STEPS].x : chain[STEPS].x;
    sin_q <= chain[STEPS].flip ? -chain[STEPS].y : chain[STEPS].y;
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

[design/seashell_surface_evaluator.sv]
// Top level of the seashell surface evaluator: point and both partials per sample.
//
// Evaluates the seashell surface at one sample (u, v) per clock. An item is taken
// at every rising edge where start_i is high; busy_o stays low because the datapath
// is a free-running pipeline with no stall. The result appears on the nine output
// ports with done_o high for exactly one cycle. Each item passes the input stage, the
// CORDIC fold stage, the two CORDIC cell chains (one step per cycle for u and for
// the sweep angle), the CORDIC output stage and five product/adjust stages behind
// them. Results cannot be held off, so capture them when done_o strikes. Write the
// four shape registers only while no item is in flight; all of them reset to 1.0.
module seashell_surface_evaluator #(
  parameter int FRAC_BITS    = ssev_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = ssev_pkg::CORDIC_STEPS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [18:0]                    angle_u_i,
  input  logic [17:0]                    sweep_v_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ssev_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  output logic                           done_o,
  output logic signed [31:0]             point_x_o,
  output logic signed [31:0]             point_y_o,
  output logic signed [31:0]             point_z_o,
  output logic signed [31:0]             du_x_o,
  output logic signed [31:0]             du_y_o,
  output logic signed [31:0]             du_z_o,
  output logic signed [31:0]             dv_x_o,
  output logic signed [31:0]             dv_y_o,
  output logic signed [31:0]             dv_z_o
);
  import ssev_pkg::*;

  localparam int LAT   = latency(CORDIC_STEPS);
  localparam int DLY   = CORDIC_STEPS + 2;          // CORDIC input to output
  localparam int PW_SH = 2 * FRAC_BITS + 1 - 32;    // n*v to turn fraction
  localparam int VX    = (FRAC_BITS < 17) ? (17 - FRAC_BITS) : 0;
  localparam int AH_W  = 34 + VX;                   // a*h
  localparam int G_W   = AH_W + 2;                  // a*h*(1+cos u) + c
  localparam int NP_W  = 35;                        // n*pi
  localparam int SN_W  = NP_W + 1;                  // n*pi*sin w
  localparam int F2_W  = 33;                        // a*(1+cos u)/2
  localparam int R2_W  = AH_W + 1;
  localparam int R5_W  = AH_W + 1;
  localparam int R8_W  = 34;
  localparam int RES_W = SN_W + G_W + 1;

  localparam logic signed [RES_W-1:0] SAT_MAX = {{(RES_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [RES_W-1:0] SAT_MIN = {{(RES_W-31){1'b1}}, 31'b0};
  localparam logic [31:0]             ONE     = 32'(64'd1 << FRAC_BITS);

  typedef struct packed {
    logic signed [AH_W-1:0] ah;
    logic signed [AH_W-1:0] bvh;
    logic signed [NP_W-1:0] npi;
  } side_t;

  function automatic logic signed [31:0] sat32(input logic signed [RES_W-1:0] x);
    logic signed [31:0] r;
    if (x > SAT_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < SAT_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [31:0] shell_width_q, shell_height_q, inner_radius_q, turn_count_q;
  logic               cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shell_width_q  <= $signed(ONE);
      shell_height_q <= $signed(ONE);
      inner_radius_q <= $signed(ONE);
      turn_count_q   <= $signed(ONE);
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        REG_SHELL_WIDTH:  shell_width_q  <= $signed(cfg_data_i);
        REG_SHELL_HEIGHT: shell_height_q <= $signed(cfg_data_i);
        REG_INNER_RADIUS: inner_radius_q <= $signed(cfg_data_i);
        REG_TURN_COUNT:   turn_count_q   <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Item tracking: one valid bit per pipeline stage
  // ---------------------------------------------------------------------------
  logic           accept;
  logic [LAT-1:0] vld_q;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], accept};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: turn fractions for u and for w, and the raw products with v and n
  // ---------------------------------------------------------------------------
  logic [63:0]        pu_full;
  logic signed [50:0] nv_prod;
  logic signed [63:0] nv_ext;
  logic [31:0]        pw;
  logic signed [50:0] av, bv;
  logic signed [62:0] np;

  logic [31:0]        pu_q, pw_q;
  logic signed [50:0] av_q, bv_q;
  logic signed [62:0] np_q;

  // u/(2 pi) as a 32-bit turn fraction, rounded
  assign pu_full = 64'(angle_u_i) * 64'(INV_TWO_PI_Q32) + (64'd1 << (FRAC_BITS - 1));
  // n*v/2 turns; only the fraction of a turn matters
  assign nv_prod = turn_count_q * $signed({1'b0, sweep_v_i});
  assign nv_ext  = 64'(nv_prod);

  if (PW_SH >= 0) begin : g_pw_right
    assign pw = nv_ext[PW_SH+31:PW_SH];
  end else begin : g_pw_left
    assign pw = 32'(nv_ext <<< (-PW_SH));
  end

  assign av = shell_width_q  * $signed({1'b0, sweep_v_i});
  assign bv = shell_height_q * $signed({1'b0, sweep_v_i});
  assign np = turn_count_q   * $signed({1'b0, PI_Q29});

  always_ff @(posedge clk_i) begin
    pu_q <= pu_full[FRAC_BITS+31:FRAC_BITS];
    pw_q <= pw;
    av_q <= av;
    bv_q <= bv;
    np_q <= np;
  end

  // ---------------------------------------------------------------------------
  // Sine and cosine of u and of w
  // ---------------------------------------------------------------------------
  trig_t cu, su, cw, sw;

  ssev_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_u (
    .clk_i   (clk_i),
    .phase_i (pu_q),
    .cos_o   (cu),
    .sin_o   (su)
  );

  ssev_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_w (
    .clk_i   (clk_i),
    .phase_i (pw_q),
    .cos_o   (cw),
    .sin_o   (sw)
  );

  // ---------------------------------------------------------------------------
  // Side line: a*h, b*v/2 and n*pi travel next to the CORDIC chains
  // ---------------------------------------------------------------------------
  side_t side_d;
  side_t side_q [DLY];

  assign side_d.ah  = AH_W'(shell_width_q) - AH_W'(av_q >>> (FRAC_BITS + 1));
  assign side_d.bvh = AH_W'(bv_q >>> (FRAC_BITS + 1));
  assign side_d.npi = NP_W'(np_q >>> 29);

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_d;
    for (int k = 1; k < DLY; k++) begin
      side_q[k] <= side_q[k-1];
    end
  end

  // ---------------------------------------------------------------------------
  // T1: 1 + cos u
  // ---------------------------------------------------------------------------
  trig_t cu_t1_q, cu1_t1_q, su_t1_q, cw_t1_q, sw_t1_q;
  side_t side_t1_q;

  always_ff @(posedge clk_i) begin
    cu_t1_q   <= cu;
    cu1_t1_q  <= TRIG_ONE + cu;
    su_t1_q   <= su;
    cw_t1_q   <= cw;
    sw_t1_q   <= sw;
    side_t1_q <= side_q[DLY-1];
  end

  // ---------------------------------------------------------------------------
  // T2: first row of products
  // ---------------------------------------------------------------------------
  logic signed [AH_W+TRIG_W-1:0] p_g_q, p_q_q, p_c_q;
  logic signed [32+TRIG_W-1:0]   p_f2_q, p_as_q;
  logic signed [NP_W+TRIG_W-1:0] p_sn_q, p_cn_q;
  logic signed [AH_W-1:0]        bvh_t2_q;
  trig_t                         cw_t2_q, sw_t2_q;

  always_ff @(posedge clk_i) begin
    p_g_q    <= side_t1_q.ah * cu1_t1_q;
    p_q_q    <= side_t1_q.ah * su_t1_q;
    p_c_q    <= side_t1_q.ah * cu_t1_q;
    p_f2_q   <= shell_width_q * cu1_t1_q;
    p_as_q   <= shell_width_q * su_t1_q;
    p_sn_q   <= side_t1_q.npi * sw_t1_q;
    p_cn_q   <= side_t1_q.npi * cw_t1_q;
    bvh_t2_q <= side_t1_q.bvh;
    cw_t2_q  <= cw_t1_q;
    sw_t2_q  <= sw_t1_q;
  end

  // ---------------------------------------------------------------------------
  // T3: scale back and form G, q, F2 and the finished z terms
  // ---------------------------------------------------------------------------
  logic signed [G_W-1:0]  g_q;
  logic signed [AH_W-1:0] q_q;
  logic signed [F2_W-1:0] f2_q;
  logic signed [SN_W-1:0] swn_q, cwn_q;
  logic signed [R2_W-1:0] r2_t3_q;
  logic signed [R5_W-1:0] r5_t3_q;
  logic signed [R8_W-1:0] r8_t3_q;
  trig_t                  cw_t3_q, sw_t3_q;
  logic signed [AH_W-1:0] q_d;

  assign q_d = AH_W'(p_q_q >>> TRIG_BITS);

  always_ff @(posedge clk_i) begin
    g_q     <= G_W'(p_g_q >>> TRIG_BITS) + G_W'(inner_radius_q);
    q_q     <= q_d;
    f2_q    <= F2_W'(p_f2_q >>> (TRIG_BITS + 1));
    swn_q   <= SN_W'(p_sn_q >>> TRIG_BITS);
    cwn_q   <= SN_W'(p_cn_q >>> TRIG_BITS);
    r2_t3_q <= R2_W'(bvh_t2_q) + R2_W'(q_d);
    r5_t3_q <= R5_W'(p_c_q >>> TRIG_BITS);
    r8_t3_q <= (R8_W'(shell_height_q) - R8_W'(p_as_q >>> TRIG_BITS)) >>> 1;
    cw_t3_q <= cw_t2_q;
    sw_t3_q <= sw_t2_q;
  end

  // ---------------------------------------------------------------------------
  // T4: second row of products against the sweep angle
  // ---------------------------------------------------------------------------
  logic signed [G_W+TRIG_W-1:0]  pgc_q, pgs_q;
  logic signed [AH_W+TRIG_W-1:0] pqc_q, pqs_q;
  logic signed [SN_W+G_W-1:0]    psg_q, pcg_q;
  logic signed [F2_W+TRIG_W-1:0] pfc_q, pfs_q;
  logic signed [R2_W-1:0]        r2_t4_q;
  logic signed [R5_W-1:0]        r5_t4_q;
  logic signed [R8_W-1:0]        r8_t4_q;

  always_ff @(posedge clk_i) begin
    pgc_q   <= g_q * cw_t3_q;
    pgs_q   <= g_q * sw_t3_q;
    pqc_q   <= q_q * cw_t3_q;
    pqs_q   <= q_q * sw_t3_q;
    psg_q   <= swn_q * g_q;
    pcg_q   <= cwn_q * g_q;
    pfc_q   <= f2_q * cw_t3_q;
    pfs_q   <= f2_q * sw_t3_q;
    r2_t4_q <= r2_t3_q;
    r5_t4_q <= r5_t3_q;
    r8_t4_q <= r8_t3_q;
  end

  // ---------------------------------------------------------------------------
  // T5: final sums, saturate, and hold on the output ports
  // ---------------------------------------------------------------------------
  logic signed [RES_W-1:0] r0, r1, r3, r4, r6, r7;
  logic signed [31:0]      px_q, py_q, pz_q, ux_q, uy_q, uz_q, vx_q, vy_q, vz_q;

  assign r0 = RES_W'(pgc_q >>> TRIG_BITS);
  assign r1 = RES_W'(pgs_q >>> TRIG_BITS);
  assign r3 = -RES_W'(pqc_q >>> TRIG_BITS);
  assign r4 = -RES_W'(pqs_q >>> TRIG_BITS);
  assign r6 = -RES_W'(psg_q >>> FRAC_BITS) - RES_W'(pfc_q >>> TRIG_BITS);
  assign r7 = RES_W'(pcg_q >>> FRAC_BITS) - RES_W'(pfs_q >>> TRIG_BITS);

  // Load only for a live item, so the ports hold between strobes.
  always_ff @(posedge clk_i) begin
    if (vld_q[LAT-2]) begin
      px_q <= sat32(r0);
      py_q <= sat32(r1);
      pz_q <= sat32(RES_W'(r2_t4_q));
      ux_q <= sat32(r3);
      uy_q <= sat32(r4);
      uz_q <= sat32(RES_W'(r5_t4_q));
      vx_q <= sat32(r6);
      vy_q <= sat32(r7);
      vz_q <= sat32(RES_W'(r8_t4_q));
    end
  end

  assign done_o    = vld_q[LAT-1];
  assign point_x_o = px_q;
  assign point_y_o = py_q;
  assign point_z_o = pz_q;
  assign du_x_o    = ux_q;
  assign du_y_o    = uy_q;
  assign du_z_o    = uz_q;
  assign dv_x_o    = vx_q;
  assign dv_y_o    = vy_q;
  assign dv_z_o    = vz_q;

endmodule

[design/ssev_checker.sv]
// Port-level checks of the seashell surface evaluator, bound to its top level.
module ssev_checker #(
  parameter int CORDIC_STEPS = ssev_pkg::CORDIC_STEPS_DEF
) (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic cfg_valid_i,
  input logic cfg_ready_o,
  input logic done_o
);
  import ssev_pkg::*;

  localparam int LAT = latency(CORDIC_STEPS);

  // Every taken item strobes its result a fixed latency later.
  a_item_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LAT done_o)
    else $error("item taken without result after fixed latency");

  // No result strobe without a matching item.
  a_done_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LAT))
    else $error("result strobe without a matching item");

  // The pipeline never stalls either channel.
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i || cfg_valid_i) |-> (!busy_o && cfg_ready_o))
    else $error("evaluator refused an item or a register write");

endmodule

bind seashell_surface_evaluator ssev_checker #(
  .CORDIC_STEPS(CORDIC_STEPS)
) u_ssev_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o),
  .done_o      (done_o)
);
